[sv/mcsi_pkg.sv]
package mcsi_pkg;

  // Field widths
  localparam int GAP_W      = 16;
  localparam int SENT_W     = 2;
  localparam int PEND_W     = 8;
  localparam int MCNT_W     = 8;
  localparam int SIXTH_W    = 3;
  localparam int QUARTER_W  = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // MIDI real-time bytes
  localparam logic [7:0] BYTE_CLOCK = 8'hf8;
  localparam logic [7:0] BYTE_START = 8'hfa;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_PERIOD = 1'd1;

  // Clock mode codes (code 3 behaves as auto)
  localparam logic [MODE_W-1:0] MODE_MASTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SLAVE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

  // Reset values of the registers
  localparam logic [MODE_W-1:0] MODE_RESET   = MODE_AUTO;
  localparam logic [MCNT_W-1:0] PERIOD_RESET = 8'd5;

  // Counter limits
  localparam logic [GAP_W-1:0]     GAP_MAX         = 16'hffff;
  localparam logic [GAP_W-1:0]     GAP_PRESENT_LIM = 16'h0fff;
  localparam logic [PEND_W-1:0]    PEND_MAX        = 8'hff;
  localparam logic [SENT_W-1:0]    INTERP_STEPS    = 2'd3;
  localparam logic [PEND_W:0]      CLOCKS_PER_F8   = 9'd4;
  localparam logic [SIXTH_W-1:0]   SIXTH_WRAP      = 3'd6;

  typedef struct packed {
    logic       operation;
    logic [7:0] realtime_byte;
  } mcsi_item_t;

  typedef struct packed {
    logic                 clock_pulse;
    logic                 start_pulse;
    logic                 slave_active;
    logic [SIXTH_W-1:0]   sixth_count;
    logic [QUARTER_W-1:0] quarter_count;
  } mcsi_result_t;

endpackage

[sv/mcsi_if.sv]
interface mcsi_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] realtime_byte;

  modport source (output valid, output operation, output realtime_byte, input ready);
  modport sink   (input valid, input operation, input realtime_byte, output ready);
endinterface

interface mcsi_out_if;
  logic       valid;
  logic       ready;
  logic       clock_pulse;
  logic       start_pulse;
  logic       slave_active;
  logic [2:0] sixth_count;
  logic [1:0] quarter_count;

  modport source (output valid, output clock_pulse, output start_pulse,
                  output slave_active, output sixth_count, output quarter_count,
                  input ready);
  modport sink   (input valid, input clock_pulse, input start_pulse,
                  input slave_active, input sixth_count, input quarter_count,
                  output ready);
endinterface

[sv/mcsi_core.sv]
module mcsi_core
  import mcsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  input  mcsi_item_t            item,
  output mcsi_result_t          result
);

  // Configuration
  logic [MODE_W-1:0] clock_mode;
  logic [MCNT_W-1:0] master_period;

  // Tracking state
  logic [GAP_W-1:0]     gap_counter,      gap_counter_next;
  logic [GAP_W-1:0]     measured_gap,     measured_gap_next;
  logic [GAP_W-1:0]     interp_countdown, interp_countdown_next;
  logic [SENT_W-1:0]    interp_sent,      interp_sent_next;
  logic [PEND_W-1:0]    pending_clocks,   pending_clocks_next;
  logic [MCNT_W-1:0]    master_counter,   master_counter_next;
  logic                 start_request,    start_request_next;
  logic [SIXTH_W-1:0]   sixth_phase,      sixth_phase_next;
  logic [QUARTER_W-1:0] quarter_phase,    quarter_phase_next;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_mode    <= MODE_RESET;
      master_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLOCK_MODE:    clock_mode    <= cfg_data[MODE_W-1:0];
        REG_MASTER_PERIOD: master_period <= cfg_data[MCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state and result for one item
  always_comb begin
    logic               slave;
    logic               clk_ev;
    logic               start_ev;
    logic [PEND_W:0]    pend_sum;
    logic [MCNT_W:0]    mcnt_inc;
    logic [SIXTH_W-1:0] sixth_inc;

    gap_counter_next      = gap_counter;
    measured_gap_next     = measured_gap;
    interp_countdown_next = interp_countdown;
    interp_sent_next      = interp_sent;
    pending_clocks_next   = pending_clocks;
    master_counter_next   = master_counter;
    start_request_next    = start_request;
    sixth_phase_next      = sixth_phase;
    quarter_phase_next    = quarter_phase;
    clk_ev    = 1'b0;
    start_ev  = 1'b0;
    pend_sum  = '0;
    mcnt_inc  = '0;
    sixth_inc = '0;

    if (item.operation == OP_BYTE) begin
      if (item.realtime_byte == BYTE_CLOCK) begin
        // clock: latch gap, make up unsent interpolated clocks
        measured_gap_next     = gap_counter;
        gap_counter_next      = '0;
        pend_sum              = {1'b0, pending_clocks} + CLOCKS_PER_F8
                                - {{(PEND_W+1-SENT_W){1'b0}}, interp_sent};
        pending_clocks_next   = pend_sum[PEND_W] ? PEND_MAX : pend_sum[PEND_W-1:0];
        interp_sent_next      = '0;
        interp_countdown_next = gap_counter >> 2;
      end else if (item.realtime_byte == BYTE_START) begin
        start_request_next  = 1'b1;
        if (gap_counter > GAP_PRESENT_LIM)
          gap_counter_next = '0;
        pending_clocks_next = '0;
        interp_sent_next    = INTERP_STEPS;
      end
    end else begin
      // tick: advance gap counter, saturating
      if (gap_counter != GAP_MAX)
        gap_counter_next = gap_counter + 1'b1;

      // interpolation countdown
      interp_countdown_next = interp_countdown - 1'b1;
      if (interp_countdown_next == '0 && interp_sent < INTERP_STEPS) begin
        interp_sent_next      = interp_sent + 1'b1;
        pending_clocks_next   = (pending_clocks == PEND_MAX) ? PEND_MAX
                                                             : pending_clocks + 1'b1;
        interp_countdown_next = measured_gap >> 2;
      end

      // start takeover
      if (start_request) begin
        start_request_next = 1'b0;
        start_ev           = 1'b1;
        sixth_phase_next   = '0;
        quarter_phase_next = '0;
      end
    end

    // slave decision on the updated gap counter
    case (clock_mode)
      MODE_MASTER: slave = 1'b0;
      MODE_SLAVE:  slave = 1'b1;
      default:     slave = gap_counter_next < GAP_PRESENT_LIM;
    endcase

    if (item.operation == OP_TICK) begin
      // clock source: requests first, then master divider
      if (pending_clocks_next != '0) begin
        pending_clocks_next = pending_clocks_next - 1'b1;
        clk_ev = slave;
      end else if (!slave) begin
        mcnt_inc = {1'b0, master_counter} + 1'b1;
        if (mcnt_inc > {1'b0, master_period}) begin
          master_counter_next = '0;
          clk_ev = 1'b1;
        end else begin
          master_counter_next = mcnt_inc[MCNT_W-1:0];
        end
      end

      // divide-by-6 and divide-by-24 phases
      if (clk_ev) begin
        sixth_inc = sixth_phase_next + 1'b1;
        if (sixth_inc >= SIXTH_WRAP) begin
          sixth_phase_next   = '0;
          quarter_phase_next = quarter_phase_next + 1'b1;
        end else begin
          sixth_phase_next = sixth_inc;
        end
      end
    end

    result.clock_pulse   = clk_ev;
    result.start_pulse   = start_ev;
    result.slave_active  = slave;
    result.sixth_count   = sixth_phase_next;
    result.quarter_count = quarter_phase_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_counter      <= '0;
      measured_gap     <= '0;
      interp_countdown <= '0;
      interp_sent      <= '0;
      pending_clocks   <= '0;
      master_counter   <= '0;
      start_request    <= 1'b0;
      sixth_phase      <= '0;
      quarter_phase    <= '0;
    end else if (step) begin
      gap_counter      <= gap_counter_next;
      measured_gap     <= measured_gap_next;
      interp_countdown <= interp_countdown_next;
      interp_sent      <= interp_sent_next;
      pending_clocks   <= pending_clocks_next;
      master_counter   <= master_counter_next;
      start_request    <= start_request_next;
      sixth_phase      <= sixth_phase_next;
      quarter_phase    <= quarter_phase_next;
    end
  end

endmodule

[sv/midi_clock_sync_interpolator_top.sv]
// Pipeline: two register stages (input register, then result register); an item
//   waits in the input register until the result register is empty or being taken.
// Throughput: one item per cycle; the input and result registers both advance
//   while the result side takes items, and the state is updated once per item.
// Reset (rst, synchronous, active high) clears all tracking state and both
//   pipeline registers, and sets clock_mode to auto and master_period to 5.
module midi_clock_sync_interpolator_top
  import mcsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mcsi_in_if.sink               events,
  mcsi_out_if.source            results
);

  logic         item_valid;
  mcsi_item_t   item;
  logic         res_valid;
  mcsi_result_t res;
  mcsi_result_t res_next;
  logic         advance;

  // Result register frees up when empty or being taken
  assign advance      = item_valid && (!res_valid || results.ready);
  assign events.ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (events.ready) begin
      item_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.ready && events.valid) begin
      item.operation     <= events.operation;
      item.realtime_byte <= events.realtime_byte;
    end
  end

  mcsi_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (item),
    .result    (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance)
      res <= res_next;
  end

  assign results.valid         = res_valid;
  assign results.clock_pulse   = res.clock_pulse;
  assign results.start_pulse   = res.start_pulse;
  assign results.slave_active  = res.slave_active;
  assign results.sixth_count   = res.sixth_count;
  assign results.quarter_count = res.quarter_count;

endmodule
